[sv/nlt_pkg.sv]
package nlt_pkg;

   // link states
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_ASYM = 2'd1;
   localparam logic [1:0] ST_SYM  = 2'd2;

   // result status codes
   localparam logic [2:0] RS_UPDATED  = 3'd0;
   localparam logic [2:0] RS_WEAK_NEW = 3'd1;
   localparam logic [2:0] RS_FULL     = 3'd2;
   localparam logic [2:0] RS_DROPPED  = 3'd3;
   localparam logic [2:0] RS_EXPIRY   = 3'd4;
   localparam logic [2:0] RS_TICK     = 3'd5;

   localparam logic [12:0] SUM_MAX = 13'd8191;

   // register indexes
   localparam logic REG_DROP  = 1'b0;
   localparam logic REG_ADMIT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch the input item, start the scan
      logic scan;      // examine the slot at the scan pointer
      logic commit;    // apply the hello decision
      logic emit;      // load the output register
      logic emit_tick; // emit the closing tick result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic scan_last;    // pointer at the final slot
      logic tick_change;  // slot under scan changes on this tick
      logic hello_found;  // known sender seen at the scan pointer
      logic out_busy;     // output register still holds an item
   } sts_type;

   // wrap-safe validity check
   function automatic logic still_valid(input logic [31:0] dl, input logic [31:0] t);
      logic [31:0] d;
      d = dl - t;
      return ~d[31];
   endfunction

endpackage

[sv/neighbor_link_table_core.sv]
// neighbor link sensing table
// req_ channel: one item per hello (req_tuser 0) or expiry tick (req_tuser 1).
// rsp_ channel: a hello gives one result; a tick gives one expiry-change
//   result per changed slot in slot order, then a tick-done result.
//   rsp_tlast marks the final result of each item.
// csr_ port: register 0 drop threshold at 0x0, register 1 admit threshold
//   at 0x4; write only while idle.
// operation: a hello scans slots one per cycle until the sender is found
//   (at most TABLE_ENTRIES slots), then commits the decision and reports;
//   a tick scans all slots and reports each change as it is found.
//   Only one item is in flight at a time: the next item is taken once the
//   final result is loaded into the output register.
// reset clears all slot states to none, the sticky change flag and both
//   thresholds. A stalled receiver holds the output register and the scan
//   waits at the next change or final result.
module neighbor_link_table_core
   import nlt_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 32,
   parameter int ENERGY_CLASSES = 4,
   parameter int ADDR_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now[31:0], neighbor_addr, link_power, validity_ticks, heard_state,
   // one_hop_count, energy_level; zero fill
   input  logic [8*((90+ADDR_BITS+7)/8)-1:0] req_tdata,
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, slot index, slot address, prior link state, next link state,
   // changed, two-hop sum, sticky change flag; zero fill
   output logic [8*((27+ADDR_BITS+7)/8)-1:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int A = ADDR_BITS;
   localparam int RW = 8*((27+A+7)/8);

   logic [7:0] drop_ff, admit_ff;
   assign csr_pready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= '0; admit_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0
                   && csr_paddr[2] == REG_DROP) begin
         drop_ff <= csr_pwdata[7:0];
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0
                   && csr_paddr[2] == REG_ADMIT) begin
         admit_ff <= csr_pwdata[7:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_DROP) ? {24'd0, drop_ff} : {24'd0, admit_ff};

   cmd_type cmd;
   sts_type sts;
   logic [2:0] o_status; logic [4:0] o_idx; logic [A-1:0] o_addr;
   logic [1:0] o_old, o_new; logic o_chg, o_sticky; logic [12:0] o_sum;

   nlt_ctrl u_ctrl (
      .clock, .reset,
      .in_fire (req_tvalid && req_tready),
      .in_ready(req_tready),
      .sts, .cmd
   );

   nlt_dp #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .ENERGY_CLASSES(ENERGY_CLASSES), .ADDR_BITS(ADDR_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .sts,
      .drop_thr(drop_ff), .admit_thr(admit_ff),
      .in_type(req_tuser),
      .in_now(req_tdata[31:0]),
      .in_addr(req_tdata[32 +: A]),
      .in_power(req_tdata[32+A +: 8]),
      .in_validity(req_tdata[40+A +: 32]),
      .in_heard(req_tdata[72+A +: 2]),
      .in_one_hop(req_tdata[74+A +: 8]),
      .in_energy(req_tdata[82+A +: 8]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(o_status), .out_index(o_idx), .out_addr(o_addr),
      .out_old(o_old), .out_new(o_new), .out_changed(o_chg),
      .out_sum(o_sum), .out_sticky(o_sticky), .out_last(rsp_tlast)
   );

   assign rsp_tdata = RW'({o_sticky, o_sum, o_chg, o_new, o_old, o_addr, o_idx, o_status});

endmodule

[sv/nlt_ctrl.sv]
module nlt_ctrl
   import nlt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_fire,
   output logic    in_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_CHANGE = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_HEMIT  = 3'd4;
   localparam logic [2:0] S_TEMIT  = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.is_tick && sts.tick_change) begin
               state_in = S_CHANGE;
            end else begin
               cmd.scan = 1'b1;
               if (!sts.is_tick && sts.hello_found) state_in = S_COMMIT;
               else if (sts.scan_last)
                  state_in = sts.is_tick ? S_TEMIT : S_COMMIT;
            end
         end
         S_CHANGE: begin
            // report the expiry and apply it, then move on
            if (!sts.out_busy) begin
               cmd.scan = 1'b1;
               cmd.emit = 1'b1;
               state_in = sts.scan_last ? S_TEMIT : S_SCAN;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_HEMIT;
         end
         S_HEMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TEMIT: begin
            if (!sts.out_busy) begin
               cmd.emit      = 1'b1;
               cmd.emit_tick = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[sv/nlt_dp.sv]
module nlt_dp
   import nlt_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 32,
   parameter int ENERGY_CLASSES = 4,
   parameter int ADDR_BITS      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [7:0]           drop_thr,
   input  logic [7:0]           admit_thr,
   input  logic                 in_type,
   input  logic [31:0]          in_now,
   input  logic [ADDR_BITS-1:0] in_addr,
   input  logic [7:0]           in_power,
   input  logic [31:0]          in_validity,
   input  logic [1:0]           in_heard,
   input  logic [7:0]           in_one_hop,
   input  logic [7:0]           in_energy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0]           out_status,
   output logic [4:0]           out_index,
   output logic [ADDR_BITS-1:0] out_addr,
   output logic [1:0]           out_old,
   output logic [1:0]           out_new,
   output logic                 out_changed,
   output logic [12:0]          out_sum,
   output logic                 out_sticky,
   output logic                 out_last
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int EW = (ENERGY_CLASSES > 1) ? $clog2(ENERGY_CLASSES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
   localparam int SW = (IW + 8 > 14) ? IW + 8 : 14;

   // slot states have reset values: flip-flops
   logic [1:0]           state_ff [TABLE_ENTRIES];
   // payload stores: memories, undefined until written
   logic [ADDR_BITS-1:0] addr_mem [TABLE_ENTRIES];
   logic [31:0]          sym_mem  [TABLE_ENTRIES];
   logic [31:0]          asym_mem [TABLE_ENTRIES];
   logic [7:0]           hop_mem  [TABLE_ENTRIES];
   logic [EW-1:0]        nrg_mem  [TABLE_ENTRIES];

   logic                 typ_ff;
   logic [31:0]          now_ff;
   logic [ADDR_BITS-1:0] adr_ff;
   logic [7:0]           pwr_ff, hop_ff, nrg_ff;
   logic [31:0]          val_ff;
   logic [1:0]           heard_ff;
   logic [IW-1:0]        ptr_ff;
   logic                 found_ff, free_ok_ff;
   logic [IW-1:0]        hit_ff, free_ff;
   logic                 sticky_ff;

   // scan read of the slot at the pointer
   logic [1:0]  cur_st;
   logic [31:0] cur_sym, cur_asym;
   logic [ADDR_BITS-1:0] cur_adr;
   logic [1:0]  tick_new;
   assign cur_st   = state_ff[ptr_ff];
   assign cur_sym  = sym_mem[ptr_ff];
   assign cur_asym = asym_mem[ptr_ff];
   assign cur_adr  = addr_mem[ptr_ff];
   assign tick_new = still_valid(cur_sym, now_ff) ? ST_SYM :
                     (still_valid(cur_asym, now_ff) ? ST_ASYM : ST_NONE);

   logic hit_now;
   assign hit_now = (cur_st != ST_NONE) && (cur_adr == adr_ff);

   assign sts.is_tick     = typ_ff;
   assign sts.scan_last   = (ptr_ff == LAST_IDX);
   assign sts.tick_change = (cur_st != ST_NONE) && (tick_new != cur_st);
   assign sts.hello_found = hit_now;
   assign sts.out_busy    = out_valid && !out_ready;

   // hello decision over the chosen slot
   logic [IW-1:0] e_idx;
   logic          e_ok, weak_new, full, drop;
   logic [1:0]    e_old, e_new;
   logic [31:0]   dl_new, e_sym, e_asym, minus1;
   logic [EW-1:0] nrg_c;
   assign e_idx    = found_ff ? hit_ff : free_ff;
   assign weak_new = !found_ff && (pwr_ff < admit_thr);
   assign full     = !found_ff && !weak_new && !free_ok_ff;
   assign e_ok     = !weak_new && !full;
   assign e_old    = found_ff ? state_ff[hit_ff] : ST_NONE;
   assign drop     = pwr_ff < drop_thr;
   assign dl_new   = now_ff + val_ff;
   assign minus1   = now_ff - 32'd1;
   assign e_asym   = dl_new;
   assign e_sym    = (heard_ff == ST_ASYM || heard_ff == ST_SYM) ? dl_new :
                     (found_ff ? sym_mem[hit_ff] : minus1);
   assign e_new    = still_valid(e_sym, now_ff) ? ST_SYM :
                     (still_valid(e_asym, now_ff) ? ST_ASYM : ST_NONE);
   assign nrg_c    = (nrg_ff >= 8'(ENERGY_CLASSES)) ? EW'(ENERGY_CLASSES - 1) : EW'(nrg_ff);

   // held hello result
   logic [2:0] h_status;
   logic [1:0] h_new;
   always_comb begin
      if (weak_new)  h_status = RS_WEAK_NEW;
      else if (full) h_status = RS_FULL;
      else if (drop) h_status = RS_DROPPED;
      else           h_status = RS_UPDATED;
      h_new = (e_ok && !drop) ? e_new : ST_NONE;
   end
   logic [2:0] hr_status_ff;
   logic [IW-1:0] hr_idx_ff;
   logic [1:0] hr_old_ff, hr_new_ff;
   logic hr_chg_ff;

   // running two-hop total, adjusted at every slot state change
   logic [SW-1:0] sum_raw_ff, sum_nxt, old_part, new_part;
   logic [12:0]   sum_sat;
   logic [7:0]    cur_hop;
   assign cur_hop = hop_mem[ptr_ff];
   always_comb begin
      old_part = '0;
      new_part = '0;
      if (cmd.scan && typ_ff && sts.tick_change) begin
         if (cur_st == ST_SYM) old_part = SW'(cur_hop);
         if (tick_new == ST_SYM) new_part = SW'(cur_hop);
      end else if (cmd.commit && e_ok) begin
         if (e_old == ST_SYM) old_part = SW'(hop_mem[e_idx]);
         if (h_new == ST_SYM) new_part = SW'(hop_ff);
      end
      sum_nxt = sum_raw_ff - old_part + new_part;
      sum_sat = (sum_nxt > SW'(SUM_MAX)) ? SUM_MAX : sum_nxt[12:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         typ_ff <= in_type; now_ff <= in_now; adr_ff <= in_addr;
         pwr_ff <= in_power; val_ff <= in_validity; heard_ff <= in_heard;
         hop_ff <= in_one_hop; nrg_ff <= in_energy;
      end
      // payload writes
      if (cmd.commit && e_ok) begin
         if (!found_ff) addr_mem[e_idx] <= adr_ff;
         if (drop) begin
            sym_mem[e_idx]  <= minus1;
            asym_mem[e_idx] <= minus1;
         end else begin
            sym_mem[e_idx]  <= e_sym;
            asym_mem[e_idx] <= e_asym;
            hop_mem[e_idx]  <= hop_ff;
            nrg_mem[e_idx]  <= nrg_c;
         end
      end
      if (cmd.commit) begin
         hr_status_ff <= h_status;
         hr_idx_ff    <= e_ok ? e_idx : '0;
         hr_old_ff    <= e_ok ? e_old : ST_NONE;
         hr_new_ff    <= h_new;
         hr_chg_ff    <= e_ok && (h_new != e_old);
      end
   end

   // control registers and slot states
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) state_ff[i] <= ST_NONE;
         sticky_ff <= 1'b0;
         ptr_ff <= '0; found_ff <= 1'b0; free_ok_ff <= 1'b0;
         hit_ff <= '0; free_ff <= '0;
         sum_raw_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         if (cmd.load) begin
            ptr_ff <= '0; found_ff <= 1'b0; free_ok_ff <= 1'b0;
         end
         if (cmd.scan) begin
            if (typ_ff) begin
               if (cur_st != ST_NONE && tick_new != cur_st) begin
                  state_ff[ptr_ff] <= tick_new;
                  sticky_ff <= 1'b1;
               end
            end else begin
               if (hit_now) begin
                  found_ff <= 1'b1; hit_ff <= ptr_ff;
               end
               if (!free_ok_ff && cur_st == ST_NONE) begin
                  free_ok_ff <= 1'b1; free_ff <= ptr_ff;
               end
            end
            if (!sts.scan_last) ptr_ff <= ptr_ff + 1'b1;
         end
         if (cmd.commit && e_ok) begin
            state_ff[e_idx] <= h_new;
            if (drop || h_new != e_old) sticky_ff <= 1'b1;
         end
         sum_raw_ff <= sum_nxt;
         if (cmd.emit) out_valid <= 1'b1;
         else if (out_valid && out_ready) out_valid <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_sum <= sum_sat;
         if (cmd.emit_tick) begin
            out_status <= RS_TICK; out_index <= '0; out_addr <= '0;
            out_old <= ST_NONE; out_new <= ST_NONE; out_changed <= 1'b0;
            out_last <= 1'b1; out_sticky <= sticky_ff;
         end else if (typ_ff) begin
            out_status <= RS_EXPIRY; out_index <= 5'(ptr_ff); out_addr <= cur_adr;
            out_old <= cur_st; out_new <= tick_new; out_changed <= 1'b1;
            out_last <= 1'b0; out_sticky <= 1'b1;
         end else begin
            out_status <= hr_status_ff; out_index <= 5'(hr_idx_ff);
            out_addr <= (hr_status_ff == RS_WEAK_NEW || hr_status_ff == RS_FULL) ?
                        adr_ff : addr_mem[hr_idx_ff];
            out_old <= hr_old_ff; out_new <= hr_new_ff; out_changed <= hr_chg_ff;
            out_last <= 1'b1; out_sticky <= sticky_ff;
         end
      end
   end

endmodule

[test/neighbor_link_table_core_test.sv]
`timescale 1ns / 1ps

module neighbor_link_table_core_test
   import nlt_pkg::*;
();

   localparam int SLOTS = 32;
   localparam int CLASSES = 4;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  index;
      logic [15:0] addr;
      logic [1:0]  old_st;
      logic [1:0]  new_st;
      logic        chg;
      logic [12:0] sum;
      logic        sticky;
      logic        last;
   } link_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   neighbor_link_table_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the neighbor table
   logic [1:0]  tbl_state [SLOTS];
   logic [15:0] tbl_addr [SLOTS];
   logic [31:0] tbl_sym_dl [SLOTS];
   logic [31:0] tbl_asym_dl [SLOTS];
   logic [7:0]  tbl_one_hop [SLOTS];
   logic [1:0]  tbl_energy [SLOTS];
   logic        tbl_sticky;
   logic [7:0]  drop_thr;
   logic [7:0]  admit_thr;

   link_result_type pending_results[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   logic hold_rsp = 1'b0;
   int  stall_left = 0;
   logic [31:0] cur_time;

   function automatic bit deadline_ok(logic [31:0] dl, logic [31:0] t);
      logic [31:0] d;
      d = dl - t;
      return !d[31];
   endfunction

   function automatic logic [1:0] slot_link_state(int i, logic [31:0] t);
      if (deadline_ok(tbl_sym_dl[i], t)) return ST_SYM;
      if (deadline_ok(tbl_asym_dl[i], t)) return ST_ASYM;
      return ST_NONE;
   endfunction

   function automatic logic [12:0] two_hop_total();
      int s;
      s = 0;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_state[i] == ST_SYM) s += tbl_one_hop[i];
      return (s > SUM_MAX) ? SUM_MAX : s[12:0];
   endfunction

   function automatic void push_result(logic [2:0] status, int idx, logic [15:0] addr,
                                       logic [1:0] os, logic [1:0] ns, logic chg,
                                       logic last);
      link_result_type r;
      r.status = status;
      r.index = idx[4:0];
      r.addr = addr;
      r.old_st = os;
      r.new_st = ns;
      r.chg = chg;
      r.sum = two_hop_total();
      r.sticky = tbl_sticky;
      r.last = last;
      pending_results.push_back(r);
   endfunction

   // table behavior for one accepted item
   function automatic void predict_link_table(logic kind, logic [31:0] t, logic [15:0] addr,
                                              logic [7:0] pwr, logic [31:0] valid,
                                              logic [1:0] heard, logic [7:0] hops,
                                              logic [7:0] energy);
      int found, free_slot, e;
      logic [1:0] os, ns;
      found = -1;
      free_slot = -1;
      if (kind) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (tbl_state[i] != ST_NONE) begin
               os = tbl_state[i];
               ns = slot_link_state(i, t);
               if (ns != os) begin
                  tbl_state[i] = ns;
                  tbl_sticky = 1'b1;
                  push_result(RS_EXPIRY, i, tbl_addr[i], os, ns, 1'b1, 1'b0);
               end
            end
         end
         push_result(RS_TICK, 0, '0, ST_NONE, ST_NONE, 1'b0, 1'b1);
         return;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (found < 0) begin
            if (tbl_state[i] != ST_NONE && tbl_addr[i] == addr) found = i;
            else if (free_slot < 0 && tbl_state[i] == ST_NONE) free_slot = i;
         end
      end
      if (found < 0) begin
         if (pwr < admit_thr) begin
            push_result(RS_WEAK_NEW, 0, addr, ST_NONE, ST_NONE, 1'b0, 1'b1);
            return;
         end
         if (free_slot < 0) begin
            push_result(RS_FULL, 0, addr, ST_NONE, ST_NONE, 1'b0, 1'b1);
            return;
         end
         e = free_slot;
         tbl_addr[e] = addr;
         tbl_sym_dl[e] = t - 1;
         tbl_asym_dl[e] = t - 1;
      end else begin
         e = found;
      end
      os = tbl_state[e];
      // weak link removes the entry
      if (pwr < drop_thr) begin
         tbl_sym_dl[e] = t - 1;
         tbl_asym_dl[e] = t - 1;
         tbl_state[e] = ST_NONE;
         tbl_sticky = 1'b1;
         push_result(RS_DROPPED, e, tbl_addr[e], os, ST_NONE, os != ST_NONE, 1'b1);
         return;
      end
      tbl_asym_dl[e] = t + valid;
      if (heard == ST_ASYM || heard == ST_SYM) tbl_sym_dl[e] = t + valid;
      tbl_one_hop[e] = hops;
      tbl_energy[e] = (energy >= CLASSES) ? 2'(CLASSES - 1) : energy[1:0];
      ns = slot_link_state(e, t);
      tbl_state[e] = ns;
      if (ns != os) tbl_sticky = 1'b1;
      push_result(RS_UPDATED, e, tbl_addr[e], os, ns, ns != os, 1'b1);
   endfunction

   // offer one item, wait for acceptance, then predict
   task automatic send_item(logic kind, logic [31:0] t, logic [15:0] addr, logic [7:0] pwr,
                            logic [31:0] valid, logic [1:0] heard, logic [7:0] hops,
                            logic [7:0] energy);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, energy, hops, heard, valid, pwr, addr, t};
      do @(posedge clock); while (!req_tready);
      predict_link_table(kind, t, addr, pwr, valid, heard, hops, energy);
      items_sent++;
   endtask

   task automatic stop_items();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic hello(logic [15:0] addr, logic [7:0] pwr, logic [31:0] valid,
                        logic [1:0] heard, logic [7:0] hops, logic [7:0] energy);
      send_item(1'b0, cur_time, addr, pwr, valid, heard, hops, energy);
   endtask

   task automatic tick();
      send_item(1'b1, cur_time, 16'($urandom), 8'($urandom), $urandom, 2'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      stop_items();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= (idx == REG_ADMIT) ? 3'd4 : 3'd0;
      csr_pwdata <= {$urandom_range(0, 1) ? 24'hffffff : 24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_ADMIT) admit_thr = value;
      else drop_thr = value;
      @(posedge clock);
   endtask

   task automatic set_thresholds(logic [7:0] drop_v, logic [7:0] admit_v);
      wait_drained();
      write_reg(REG_DROP, drop_v);
      write_reg(REG_ADMIT, admit_v);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      link_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.index = rsp_tdata[7:3];
         got.addr = rsp_tdata[23:8];
         got.old_st = rsp_tdata[25:24];
         got.new_st = rsp_tdata[27:26];
         got.chg = rsp_tdata[28];
         got.sum = rsp_tdata[41:29];
         got.sticky = rsp_tdata[42];
         got.last = rsp_tlast;
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.addr !== want.addr || got.old_st !== want.old_st ||
                got.new_st !== want.new_st || got.chg !== want.chg ||
                got.sum !== want.sum || got.sticky !== want.sticky ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: st %0d/%0d idx %0d/%0d addr %h/%h old %0d/%0d",
                            " new %0d/%0d chg %0d/%0d sum %0d/%0d stk %0d/%0d",
                            " last %0d/%0d (exp/act)"},
                           want.status, got.status, want.index, got.index, want.addr,
                           got.addr, want.old_st, got.old_st, want.new_st, got.new_st,
                           want.chg, got.chg, want.sum, got.sum, want.sticky, got.sticky,
                           want.last, got.last);
            end
         end
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 17);
      rsp_tready <= !reset && !hold_rsp && stall_left == 0;
      if (stall_left > 0) stall_left--;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_directed();
      set_thresholds(8'd0, 8'd0);
      cur_time = 32'hffff_ff00;
      hello(16'h0000, 8'd255, 32'd100, 2'd2, 8'd255, 8'd255);
      hello(16'hffff, 8'd0, 32'd100, 2'd1, 8'd0, 8'd0);
      hello(16'h1234, 8'd128, 32'd300, 2'd0, 8'd17, 8'd3);
      hello(16'h1234, 8'd128, 32'd0, 2'd3, 8'd1, 8'd2);
      // validity of half the range expires at once, slot stays free
      hello(16'h5555, 8'd9, 32'h8000_0000, 2'd2, 8'd5, 8'd1);
      hello(16'haaaa, 8'd9, 32'h7fff_ffff, 2'd2, 8'd200, 8'd4);
      tick();
      cur_time = cur_time + 150;   // still short of the wrap; the next step wraps through zero
      tick();
      cur_time = cur_time + 250;
      tick();
      hello(16'h0000, 8'd255, 32'hffff_ffff, 2'd2, 8'd3, 8'd0);
      set_thresholds(8'd100, 8'd200);
      hello(16'h7777, 8'd10, 32'd50, 2'd2, 8'd1, 8'd1);
      hello(16'h0000, 8'd50, 32'd50, 2'd2, 8'd1, 8'd1);
      hello(16'haaaa, 8'd99, 32'd50, 2'd2, 8'd1, 8'd1);
      set_thresholds(8'd100, 8'd50);
      // admitted then dropped straight away
      hello(16'h4321, 8'd60, 32'd50, 2'd2, 8'd1, 8'd1);
      hello(16'h4321, 8'd100, 32'd50, 2'd1, 8'd1, 8'd1);
      set_thresholds(8'd255, 8'd255);
      hello(16'h4321, 8'd254, 32'd50, 2'd1, 8'd1, 8'd1);
      hello(16'h9999, 8'd255, 32'd50, 2'd1, 8'd1, 8'd1);
      tick();
   endtask

   task automatic test_table_full();
      set_thresholds(8'd0, 8'd0);
      cur_time = $urandom;
      for (int i = 0; i < 34; i++)
         hello(16'(16'h2000 + i), 8'($urandom), 32'd5000, 2'd2, 8'd255, 8'($urandom));
      tick();
      cur_time = cur_time + 6000;
      tick();
   endtask

   task automatic random_burst(int n);
      logic [15:0] a;
      logic [31:0] v;
      for (int i = 0; i < n; i++) begin
         cur_time = cur_time + $urandom_range(0, 25);
         if ($urandom_range(0, 4) == 0) begin
            tick();
         end else begin
            a = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 39) * 16'h0411);
            v = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80);
            hello(a, 8'($urandom), v, 2'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_random();
      logic [7:0] d, m;
      cur_time = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         d = $urandom_range(0, 60);
         m = $urandom_range(0, 120);
         if (phase == 3) begin
            d = 8'd0;
            m = 8'd0;
         end
         set_thresholds(d, m);
         random_burst(27);
      end
   endtask

   task automatic test_backpressure();
      set_thresholds(8'd20, 8'd10);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         random_burst(20);
      join
   endtask

   task automatic test_no_idle();
      wait_drained();
      idle_on = 1'b0;
      random_burst(30);
   endtask

   initial begin
      cur_time = '0;
      drop_thr = '0;
      admit_thr = '0;
      tbl_sticky = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_state[i] = ST_NONE;
         tbl_addr[i] = '0;
         tbl_sym_dl[i] = '0;
         tbl_asym_dl[i] = '0;
         tbl_one_hop[i] = '0;
         tbl_energy[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random();
      test_backpressure();
      test_no_idle();
      wait_drained();
      $display("sent %0d items (hellos, ticks, full table, weak links, drops)", items_sent);
      $display("checked %0d results, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
